### src/packbits_row_decoder_top_macros.svh
// Assertion macros for the PackBits row decoder.
// Used by packbits_row_decoder_top; no other dependencies.
`ifndef PACKBITS_ROW_DECODER_TOP_MACROS_SVH
`define PACKBITS_ROW_DECODER_TOP_MACROS_SVH
`ifndef SYNTH
`define PBRD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pbrd assertion failed");
`define PBRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pbrd assertion failed");
`else
`define PBRD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PBRD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### src/pbrd_pkg.sv
// Shared types and constants for the PackBits row decoder.
// No dependencies.
package pbrd_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 2;
	localparam int unsigned HDR_RUN_BIT     = 7;
	localparam logic [8:0]  REPEAT_BASE     = 9'd257;

	typedef enum logic [2:0] {
		PH_HEADER  = 3'b001,
		PH_LITERAL = 3'b010,
		PH_RUN     = 3'b100
	} phase_t;

	typedef struct packed {
		logic [15:0] element_value;
		logic [7:0]  run_length;
		logic        last_of_row;
		logic        truncated;
	} item_t;

endpackage

### src/pbrd_front.sv
// Front end: takes packed bytes, tracks packet state, emits decoded items.
// Depends on pbrd_pkg.
module pbrd_front
	import pbrd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wide,
	input  logic       accept,
	input  logic [7:0] data_byte,
	input  logic       row_end,
	output logic       push,
	output item_t      item
);

	phase_t     phase_q, phase_d;
	logic [7:0] remain_q, remain_d;
	logic [7:0] repeat_q, repeat_d;
	logic [7:0] held_q, held_d;
	logic       half_q, half_d;
	logic [7:0] remain_dec;
	logic       finished;

	always_comb begin
		phase_d    = phase_q;
		remain_d   = remain_q;
		repeat_d   = repeat_q;
		held_d     = held_q;
		half_d     = half_q;
		push       = 1'b0;
		item       = '0;
		remain_dec = remain_q;
		finished   = 1'b1;
		if (accept) begin
			if (phase_q == PH_HEADER) begin
				if (!data_byte[HDR_RUN_BIT]) begin
					remain_d = data_byte + 8'd1;
					phase_d  = PH_LITERAL;
				end else begin
					repeat_d = 8'(REPEAT_BASE - {1'b0, data_byte});
					phase_d  = PH_RUN;
				end
				half_d = 1'b0;
				if (row_end) begin
					push             = 1'b1;
					item.last_of_row = 1'b1;
					item.truncated   = 1'b1;
				end
			end else if (!half_q && wide) begin
				held_d = data_byte;
				half_d = 1'b1;
				if (row_end) begin
					push             = 1'b1;
					item.last_of_row = 1'b1;
					item.truncated   = 1'b1;
				end
			end else begin
				item.element_value = half_q ? {held_q, data_byte} : {8'd0, data_byte};
				half_d = 1'b0;
				if (phase_q == PH_LITERAL) begin
					if (remain_q != 8'd0)
						remain_dec = remain_q - 8'd1;
					remain_d        = remain_dec;
					finished        = (remain_dec == 8'd0);
					item.run_length = 8'd1;
				end else begin
					item.run_length = repeat_q;
				end
				if (finished)
					phase_d = PH_HEADER;
				push             = 1'b1;
				item.last_of_row = row_end;
				item.truncated   = row_end && !finished;
			end
			if (row_end) begin
				phase_d  = PH_HEADER;
				remain_d = '0;
				repeat_d = '0;
				held_d   = '0;
				half_d   = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			remain_q <= '0;
			repeat_q <= '0;
			held_q   <= '0;
			half_q   <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			remain_q <= remain_d;
			repeat_q <= repeat_d;
			held_q   <= held_d;
			half_q   <= half_d;
		end
	end

endmodule

### src/pbrd_queue.sv
// Short flip-flop FIFO between the front and back ends.
// Depends on pbrd_pkg.
module pbrd_queue
	import pbrd_pkg::*;
#(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  item_t                      push_item,
	input  logic                       pop,
	output item_t                      head,
	output logic                       not_empty,
	output logic                       full,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	item_t         mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign not_empty = (count_q != '0);
	assign full      = (count_q == CW'(DEPTH));
	assign head      = mem_q[rd_ptr_q];
	assign count     = count_q;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (do_push && !do_pop)
				count_q <= count_q + CW'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CW'(1);
		end
	end

endmodule

### src/pbrd_back.sv
// Back end: output register that drains the queue onto the result channel.
// Depends on pbrd_pkg.
module pbrd_back
	import pbrd_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  q_not_empty,
	input  item_t q_head,
	output logic  q_pop,
	input  logic  out_ready,
	output logic  out_valid,
	output item_t out_item
);

	logic  valid_q;
	item_t item_q;

	assign q_pop     = q_not_empty && (!valid_q || out_ready);
	assign out_valid = valid_q;
	assign out_item  = item_q;

	always_ff @(posedge clk) begin
		if (q_pop)
			item_q <= q_head;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

endmodule

### src/packbits_row_decoder_top.sv
// PackBits row decoder, top level: front end, queue, back end, config register.
// Depends on pbrd_pkg, pbrd_front, pbrd_queue, pbrd_back and the macros header.
// One packed byte is taken per cycle while the queue is not full; at most one
// result leaves per cycle. Each result passes through the queue into the output
// register. The front end's per-byte header and counter update sets the byte
// rate; the QUEUE_DEPTH-entry queue lets input and output stall independently.
`include "packbits_row_decoder_top_macros.svh"
module packbits_row_decoder_top
	import pbrd_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        row_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] element_value,
	output logic [7:0]  run_length,
	output logic        last_of_row,
	output logic        truncated
);

	logic                             wide_q;
	logic                             accept;
	logic                             f_push;
	item_t                            f_item;
	item_t                            q_head;
	logic                             q_not_empty, q_full, q_pop;
	logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;
	item_t                            o_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			wide_q <= 1'b0;
		else if (cfg_we)
			wide_q <= cfg_wdata;
	end

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	pbrd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.wide      (wide_q),
		.accept    (accept),
		.data_byte (data_byte),
		.row_end   (row_end),
		.push      (f_push),
		.item      (f_item)
	);

	pbrd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (f_push),
		.push_item (f_item),
		.pop       (q_pop),
		.head      (q_head),
		.not_empty (q_not_empty),
		.full      (q_full),
		.count     (q_count)
	);

	pbrd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.out_item    (o_item)
	);

	assign element_value = o_item.element_value;
	assign run_length    = o_item.run_length;
	assign last_of_row   = o_item.last_of_row;
	assign truncated     = o_item.truncated;

	`PBRD_ASSERT_IMPL(a_row_end_pushes, clk, arst_n, accept && row_end, f_push)
	`PBRD_ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1, q_count <= QUEUE_DEPTH)
	`PBRD_ASSERT_NEXT(a_push_lands, clk, arst_n, f_push && !q_pop, q_not_empty)

endmodule
